### rtl/core/upu_pkg.sv
// ----------------------------------------------------------------------------
// upu_pkg
// shared types, constants and tables of the polyphase upsampler
// ----------------------------------------------------------------------------
package upu_pkg;

    localparam int PHASES      = 4;
    localparam int PH_W        = 2;
    localparam int NOISE_ORDER = 5;
    localparam int NS_SLOTS    = 8;
    localparam int SAMPLE_W    = 24;
    localparam int COEF_W      = 32;
    localparam int ACC_W       = 64;
    localparam int ERR_W       = 24;
    localparam int GAIN_W      = 32;
    localparam int NSC_W       = 29;

    localparam logic [31:0] SEED_RESET = 32'h9E37_79B9;

    // configuration register indexes
    localparam logic [2:0] CFG_TAPS   = 3'd0;
    localparam logic [2:0] CFG_GAIN   = 3'd1;
    localparam logic [2:0] CFG_OUT24  = 3'd2;
    localparam logic [2:0] CFG_NS_ON  = 3'd3;
    localparam logic [2:0] CFG_DITHER = 3'd4;
    localparam logic [2:0] CFG_SEED   = 3'd5;
    localparam logic [2:0] CFG_RATE48 = 3'd6;

    // input opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_COEF   = 1'b1;

    typedef struct packed {
        logic [12:0] taps;
        logic [31:0] gain;
        logic        out24;
        logic        ns_on;
        logic        dither_on;
        logic        rate48;
    } cfg_t;

    typedef struct packed {
        logic             valid;
        logic [ACC_W-1:0] acc;
        logic [PH_W-1:0]  phase;
    } mac_res_t;

    typedef enum logic [1:0] {
        M_IDLE,
        M_ISSUE,
        M_DRAIN,
        M_HAND
    } mac_state_t;

    typedef enum logic [3:0] {
        P_IDLE,
        P_MLO,
        P_MHI,
        P_SCALE,
        P_FB,
        P_SHAPE,
        P_DA,
        P_DB,
        P_QSUM,
        P_QCLIP,
        P_ROUND,
        P_OUT
    } post_state_t;

    // error feedback coefficients, q.24
    function automatic logic signed [NSC_W-1:0] ns_coef(input logic sel, input logic [2:0] k);
        logic signed [NSC_W-1:0] c;
        begin
            case (k)
                3'd0:    c = sel ? -29'sd76093175  : -29'sd74695459;
                3'd1:    c = sel ? 29'sd145097873  : 29'sd141181705;
                3'd2:    c = sel ? -29'sd145097873 : -29'sd141181705;
                3'd3:    c = sel ? 29'sd76093175   : 29'sd74695459;
                3'd4:    c = -29'sd16777216;
                default: c = '0;
            endcase
            return c;
        end
    endfunction

endpackage

### rtl/core/polyphase_upsampler_noise_shaped_unit.sv
// ----------------------------------------------------------------------------
// polyphase_upsampler_noise_shaped_unit
// four-times polyphase fir interpolator with error feedback and tpdf dither
// ----------------------------------------------------------------------------
// pacing: set by the single multiply-accumulate path on the one coefficient read
//   port, one tap a cycle, or with few taps by the scaling of each phase; a new
//   sample item is taken only once the last phase sum is handed on
// coefficient write items give no result
// reset: configuration and control registers to defaults, history reads as zero
//   through a fill count, no clearing pass; coefficient memory is not cleared
// ----------------------------------------------------------------------------
module polyphase_upsampler_noise_shaped_unit
    import upu_pkg::*;
#(
    parameter int MAX_TAPS_PER_PHASE = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // sample and coefficient items
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       opcode,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic [13:0]                coef_index,
    input  logic signed [COEF_W-1:0]   coef_value,
    // output items
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] out_sample,
    output logic [PH_W-1:0]            phase_index,
    output logic                       last_of_frame,
    // configuration writes
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [2:0]                 cfg_index,
    input  logic [31:0]                cfg_data
);

    cfg_t     cfg_reg;
    logic     cfg_wr;
    logic     seed_wr;
    logic     in_acc;
    logic     mac_idle;
    mac_res_t mac_res;
    logic     post_ready;

    // config port never stalls
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign seed_wr   = cfg_wr && (cfg_index == CFG_SEED);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.taps      <= 13'd256;
            cfg_reg.gain      <= 32'd4194304;
            cfg_reg.out24     <= 1'b1;
            cfg_reg.ns_on     <= 1'b0;
            cfg_reg.dither_on <= 1'b0;
            cfg_reg.rate48    <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                CFG_TAPS:   cfg_reg.taps      <= cfg_data[12:0];
                CFG_GAIN:   cfg_reg.gain      <= cfg_data;
                CFG_OUT24:  cfg_reg.out24     <= cfg_data[0];
                CFG_NS_ON:  cfg_reg.ns_on     <= cfg_data[0];
                CFG_DITHER: cfg_reg.dither_on <= cfg_data[0];
                CFG_RATE48: cfg_reg.rate48    <= cfg_data[0];
                // seed goes straight into the generator state
                default: ;
            endcase
        end
    end

    // new items only while the sequencer is between samples
    assign in_ready = mac_idle;
    assign in_acc   = in_valid && in_ready;

    upu_mac #(
        .MAX_TAPS_PER_PHASE(MAX_TAPS_PER_PHASE)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_acc    (in_acc),
        .opcode    (opcode),
        .sample_in (sample_in),
        .coef_index(coef_index),
        .coef_value(coef_value),
        .idle      (mac_idle),
        .res       (mac_res),
        .res_ready (post_ready)
    );

    // scaling and quantizing of one phase overlaps the next phase's taps
    upu_post u_post (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .seed_wr      (seed_wr),
        .seed         (cfg_data),
        .res          (mac_res),
        .res_ready    (post_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_sample   (out_sample),
        .phase_index  (phase_index),
        .last_of_frame(last_of_frame)
    );

endmodule

### rtl/core/upu_mac.sv
// ----------------------------------------------------------------------------
// upu_mac
// coefficient and history memories with the multiply-accumulate sequencer
// ----------------------------------------------------------------------------
module upu_mac
    import upu_pkg::*;
#(
    parameter int MAX_TAPS_PER_PHASE = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfg_t                       cfg,
    input  logic                       in_acc,
    input  logic                       opcode,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic [13:0]                coef_index,
    input  logic signed [COEF_W-1:0]   coef_value,
    output logic                       idle,
    output mac_res_t                   res,
    input  logic                       res_ready
);

    localparam int CD = PHASES * MAX_TAPS_PER_PHASE;
    localparam int AW = (MAX_TAPS_PER_PHASE > 1) ? $clog2(MAX_TAPS_PER_PHASE) : 1;
    localparam int CW = $clog2(CD);
    localparam int TW = $clog2(MAX_TAPS_PER_PHASE + 1);

    logic signed [COEF_W-1:0]   coef_mem [CD];
    logic signed [SAMPLE_W-1:0] hist_mem [MAX_TAPS_PER_PHASE];

    mac_state_t state_reg, state_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [TW-1:0] fill_reg, fill_next;
    logic [TW-1:0] taps_reg, taps_next;
    logic [TW-1:0] age_reg, age_next;
    logic [AW-1:0] base_reg, base_next;
    logic [AW-1:0] hist_addr_reg, hist_addr_next;
    logic [CW-1:0] coef_addr_reg, coef_addr_next;
    logic [PH_W-1:0] phase_reg, phase_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic s1_v_reg, s1_ok_reg, s2_v_reg;
    logic signed [COEF_W-1:0]   coef_q_reg;
    logic signed [SAMPLE_W-1:0] hist_q_reg;
    logic signed [COEF_W+SAMPLE_W-1:0] prod_reg;

    logic          issue;
    logic          coef_we;
    logic          samp_we;
    logic [TW-1:0] taps_c;
    logic [AW-1:0] start_c;
    int            start_i;

    assign coef_we = in_acc && (opcode == OP_COEF) && (32'(coef_index) < CD);
    assign samp_we = in_acc && (opcode == OP_SAMPLE);

    // clamp tap count, find oldest history slot used
    always_comb
    begin
        if (32'(cfg.taps) > MAX_TAPS_PER_PHASE)
            taps_c = TW'(MAX_TAPS_PER_PHASE);
        else
            taps_c = TW'(cfg.taps);
        start_i = int'(wp_reg) + MAX_TAPS_PER_PHASE + 1 - int'(taps_c);
        if (start_i >= MAX_TAPS_PER_PHASE)
            start_i = start_i - MAX_TAPS_PER_PHASE;
        start_c = AW'(start_i);
    end

    always_ff @(posedge clk)
    begin
        if (coef_we)
            coef_mem[CW'(coef_index)] <= coef_value;
        coef_q_reg <= coef_mem[coef_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (samp_we)
            hist_mem[wp_reg] <= sample_in;
        hist_q_reg <= hist_mem[hist_addr_reg];
    end

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        taps_next      = taps_reg;
        age_next       = age_reg;
        base_next      = base_reg;
        hist_addr_next = hist_addr_reg;
        coef_addr_next = coef_addr_reg;
        phase_next     = phase_reg;
        issue          = 1'b0;
        acc_next       = acc_reg;
        if (s2_v_reg)
            acc_next = acc_reg + {{(ACC_W-COEF_W-SAMPLE_W){prod_reg[COEF_W+SAMPLE_W-1]}},
                                  prod_reg};
        case (state_reg)
            M_IDLE:
            begin
                if (samp_we)
                begin
                    wp_next = (wp_reg == AW'(MAX_TAPS_PER_PHASE - 1)) ? '0 : wp_reg + 1'b1;
                    if (fill_reg != TW'(MAX_TAPS_PER_PHASE))
                        fill_next = fill_reg + 1'b1;
                    taps_next      = taps_c;
                    base_next      = start_c;
                    hist_addr_next = start_c;
                    coef_addr_next = '0;
                    phase_next     = '0;
                    age_next       = taps_c - 1'b1;
                    acc_next       = '0;
                    state_next     = (taps_c == '0) ? M_HAND : M_ISSUE;
                end
            end
            M_ISSUE:
            begin
                issue          = 1'b1;
                hist_addr_next = (hist_addr_reg == AW'(MAX_TAPS_PER_PHASE - 1)) ? '0 :
                                 hist_addr_reg + 1'b1;
                coef_addr_next = coef_addr_reg + 1'b1;
                age_next       = age_reg - 1'b1;
                if (age_reg == '0)
                    state_next = M_DRAIN;
            end
            M_DRAIN:
            begin
                if (!s1_v_reg && !s2_v_reg)
                    state_next = M_HAND;
            end
            M_HAND:
            begin
                if (res_ready)
                begin
                    if (phase_reg == PH_W'(PHASES - 1))
                        state_next = M_IDLE;
                    else
                    begin
                        phase_next     = phase_reg + 1'b1;
                        hist_addr_next = base_reg;
                        age_next       = taps_reg - 1'b1;
                        acc_next       = '0;
                        state_next     = (taps_reg == '0) ? M_HAND : M_ISSUE;
                    end
                end
            end
            default: state_next = M_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            wp_reg    <= '0;
            fill_reg  <= '0;
            s1_v_reg  <= 1'b0;
            s1_ok_reg <= 1'b0;
            s2_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            fill_reg  <= fill_next;
            s1_v_reg  <= issue;
            // slots never written since reset read as zero
            s1_ok_reg <= issue && (age_reg < fill_reg);
            s2_v_reg  <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        taps_reg      <= taps_next;
        age_reg       <= age_next;
        base_reg      <= base_next;
        hist_addr_reg <= hist_addr_next;
        coef_addr_reg <= coef_addr_next;
        phase_reg     <= phase_next;
        acc_reg       <= acc_next;
        // signed product at full width, sign extended into the accumulator
        if (s1_ok_reg)
            prod_reg <= coef_q_reg * hist_q_reg;
        else
            prod_reg <= '0;
    end

    assign idle      = (state_reg == M_IDLE);
    assign res.valid = (state_reg == M_HAND);
    assign res.acc   = acc_reg;
    assign res.phase = phase_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= TW'(MAX_TAPS_PER_PHASE))
        else $error("history fill count beyond depth");

    a_hand_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (!s1_v_reg && !s2_v_reg))
        else $error("phase sum handed over with products in flight");

    a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(wp_reg) < MAX_TAPS_PER_PHASE)
        else $error("write position beyond ring");

endmodule

### rtl/core/upu_post.sv
// ----------------------------------------------------------------------------
// upu_post
// gain scaling, error feedback, dither, rounding, clipping and output register
// ----------------------------------------------------------------------------
module upu_post
    import upu_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfg_t                       cfg,
    input  logic                       seed_wr,
    input  logic [31:0]                seed,
    input  mac_res_t                   res,
    output logic                       res_ready,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] out_sample,
    output logic [PH_W-1:0]            phase_index,
    output logic                       last_of_frame
);

    localparam int KW    = $clog2(NOISE_ORDER + 1);
    localparam int EW    = (NOISE_ORDER > 1) ? $clog2(NOISE_ORDER) : 1;
    localparam int VAL_W = 48;
    localparam int FB_W  = 58;
    localparam int Q_W   = 50;
    localparam logic [VAL_W-1:0] LIMIT = VAL_W'(1) << 46;
    localparam logic signed [Q_W-1:0] Q24_MAX = 50'sd8388607 <<< 20;
    localparam logic signed [Q_W-1:0] Q24_MIN = -(50'sd8388608 <<< 20);
    localparam logic signed [Q_W-1:0] Q16_MAX = 50'sd32767 <<< 20;
    localparam logic signed [Q_W-1:0] Q16_MIN = -(50'sd32768 <<< 20);

    function automatic logic [31:0] xs32(input logic [31:0] x);
        logic [31:0] v;
        begin
            v = x ^ (x << 13);
            v = v ^ (v >> 17);
            v = v ^ (v << 5);
            return v;
        end
    endfunction

    post_state_t state_reg, state_next;
    logic [31:0] dstate_reg, dstate_next;
    logic signed [ERR_W-1:0] err_reg [NOISE_ORDER];
    logic signed [ERR_W-1:0] err_next [NOISE_ORDER];
    logic out_valid_reg, out_valid_next;

    logic              neg_reg;
    logic [ACC_W-1:0]  mag_reg;
    logic [63:0]       plo_reg, phi_reg;
    logic signed [VAL_W-1:0] val_reg;
    logic [KW-1:0]     k_reg;
    logic signed [NSC_W+ERR_W-1:0] fbp_reg;
    logic signed [FB_W-1:0] fb_reg;
    logic signed [Q_W-1:0]  shaped_reg, q_reg;
    logic [14:0]       da_reg, db_reg;
    logic              qneg_reg, hi_reg, lo_reg;
    logic [Q_W-1:0]    qmag_reg;
    logic [PH_W-1:0]   phase_reg;
    logic signed [SAMPLE_W-1:0] rnd_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic [PH_W-1:0]   out_phase_reg;

    logic [VAL_W-1:0]       r_c;
    logic [63:0]            plo_rnd;
    logic signed [FB_W-1:0] fbr_c;
    logic signed [15:0]     dd_c;
    logic [Q_W-1:0]         rm_c;
    logic signed [Q_W-1:0]  rs_c;
    logic signed [Q_W-1:0]  e_c;
    logic                   load;

    // gain product back to q.20 output lsbs, saturated; also rounds the feedback sum and quantizer
    always_comb
    begin
        plo_rnd = plo_reg + (64'd1 << 29);
        if (phi_reg >= (64'd1 << 44))
            r_c = LIMIT;
        else
        begin
            r_c = {2'b00, phi_reg[43:0], 2'b00} + VAL_W'(plo_rnd[63:30]);
            if (r_c > LIMIT)
                r_c = LIMIT;
        end
        fbr_c = (fb_reg + FB_W'(64'sd8388608)) >>> 24;
        dd_c  = $signed({1'b0, da_reg}) - $signed({1'b0, db_reg});
        rm_c  = (qmag_reg + Q_W'(64'd524288)) >> 20;
        rs_c  = qneg_reg ? -$signed(rm_c) : $signed(rm_c);
        e_c   = (rs_c <<< 20) - shaped_reg;
    end

    assign load = (state_reg == P_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        dstate_next    = dstate_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
            out_valid_next = 1'b0;
        if (load)
            out_valid_next = 1'b1;
        case (state_reg)
            P_IDLE:  if (res.valid) state_next = P_MLO;
            P_MLO:   state_next = P_MHI;
            P_MHI:   state_next = P_SCALE;
            P_SCALE: state_next = P_FB;
            P_FB:
            begin
                if (!cfg.ns_on || k_reg == KW'(NOISE_ORDER))
                    state_next = P_SHAPE;
            end
            P_SHAPE: state_next = cfg.dither_on ? P_DA : P_QSUM;
            P_DA:
            begin
                dstate_next = xs32(dstate_reg);
                state_next  = P_DB;
            end
            P_DB:
            begin
                dstate_next = xs32(dstate_reg);
                state_next  = P_QSUM;
            end
            P_QSUM:  state_next = P_QCLIP;
            P_QCLIP: state_next = P_ROUND;
            P_ROUND:
            begin
                if (hi_reg || lo_reg)
                begin
                    // clipping wipes the error history
                    for (int i = 0; i < NOISE_ORDER; i++)
                        err_next[i] = '0;
                end
                else if (cfg.ns_on)
                begin
                    for (int i = NOISE_ORDER - 1; i > 0; i--)
                        err_next[i] = err_reg[i-1];
                    err_next[0] = ERR_W'(e_c);
                end
                state_next = P_OUT;
            end
            P_OUT:   if (load) state_next = P_IDLE;
            default: state_next = P_IDLE;
        endcase
        if (seed_wr)
            dstate_next = seed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= P_IDLE;
            dstate_reg    <= SEED_RESET;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NOISE_ORDER; i++)
                err_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            dstate_reg    <= dstate_next;
            out_valid_reg <= out_valid_next;
            err_reg       <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            P_IDLE:
            begin
                neg_reg   <= res.acc[ACC_W-1];
                mag_reg   <= res.acc[ACC_W-1] ? -res.acc : res.acc;
                phase_reg <= res.phase;
            end
            P_MLO: plo_reg <= mag_reg[31:0] * cfg.gain;
            P_MHI: phi_reg <= mag_reg[63:32] * cfg.gain;
            P_SCALE:
            begin
                val_reg <= neg_reg ? -$signed(r_c) : $signed(r_c);
                k_reg   <= '0;
                fb_reg  <= '0;
            end
            P_FB:
            begin
                if (k_reg < KW'(NOISE_ORDER))
                    fbp_reg <= ns_coef(cfg.rate48, 3'(k_reg)) * err_reg[k_reg[EW-1:0]];
                if (k_reg != '0)
                    fb_reg <= fb_reg + FB_W'(fbp_reg);
                k_reg <= k_reg + 1'b1;
            end
            P_SHAPE:
            begin
                shaped_reg <= cfg.ns_on ? Q_W'(val_reg) + Q_W'(fbr_c) : Q_W'(val_reg);
                da_reg     <= '0;
                db_reg     <= '0;
            end
            P_DA: da_reg <= dstate_next[31:17];
            P_DB: db_reg <= dstate_next[31:17];
            P_QSUM: q_reg <= shaped_reg + (Q_W'(dd_c) <<< 5);
            P_QCLIP:
            begin
                hi_reg   <= q_reg >= (cfg.out24 ? Q24_MAX : Q16_MAX);
                lo_reg   <= q_reg <= (cfg.out24 ? Q24_MIN : Q16_MIN);
                qneg_reg <= q_reg[Q_W-1];
                qmag_reg <= q_reg[Q_W-1] ? -q_reg : q_reg;
            end
            P_ROUND:
            begin
                if (hi_reg)
                    rnd_reg <= cfg.out24 ? 24'sd8388607 : 24'sd32767;
                else if (lo_reg)
                    rnd_reg <= cfg.out24 ? -24'sd8388608 : -24'sd32768;
                else
                    rnd_reg <= SAMPLE_W'(rs_c);
            end
            default: ;
        endcase
        if (load)
        begin
            out_sample_reg <= rnd_reg;
            out_phase_reg  <= phase_reg;
        end
    end

    assign res_ready     = (state_reg == P_IDLE);
    assign out_valid     = out_valid_reg;
    assign out_sample    = out_sample_reg;
    assign phase_index   = out_phase_reg;
    assign last_of_frame = (out_phase_reg == PH_W'(PHASES - 1));

    a_clip_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == P_ROUND) |-> !(hi_reg && lo_reg))
        else $error("both clip limits hit");

    a_clip_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == P_ROUND && hi_reg) |=> (err_reg[0] == '0))
        else $error("error history kept after clipping");

    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res_ready) |=> (state_reg == P_MLO))
        else $error("phase sum taken without starting scaling");

endmodule
